[design/crt_pkg.sv]
// ----------------------------------------------------------------------------
// crt_pkg
// Shared widths, codes and types of the CRT submatrix index map.
// ----------------------------------------------------------------------------
package crt_pkg;

    localparam int MAX_DIM   = 64;
    localparam int DIM_W     = 7;
    localparam int ROW_W     = 12;
    localparam int COL_W     = 12;
    localparam int ST_W      = 2;
    localparam int DIV_W     = 2 * DIM_W;
    localparam int X_W       = 20;
    localparam int STEPS     = 4;
    localparam int K_STAGES  = ROW_W / STEPS;
    localparam int F_STAGES  = X_W / STEPS;
    localparam int PIPE_DEPTH = K_STAGES + 1 + F_STAGES + 1;
    localparam int CFG_IDX_W = 8;

    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_SIZE    = 2'd1;
    localparam logic [ST_W-1:0] ST_COPRIME = 2'd2;
    localparam logic [ST_W-1:0] ST_RANGE   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_DIM_N = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIM_M = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SUB_K = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SUB_L = 8'd3;

    typedef struct packed {
        logic             busy;
        logic [ST_W-1:0]  status;
        logic [DIM_W-1:0] sub_k;
        logic [DIM_W-1:0] sub_l;
        logic [DIV_W-1:0] nm;
        logic [DIV_W-1:0] kl;
        logic [DIV_W-1:0] coef_a;
        logic [DIV_W-1:0] coef_b;
    } crt_cfg_t;

    typedef struct packed {
        logic [DIV_W-1:0] rem;
        logic [X_W-1:0]   x;
    } crt_mod_t;

endpackage

[design/crt_bezout.sv]
// ----------------------------------------------------------------------------
// crt_bezout
// Configuration registers and the sequencer that derives the CRT weights.
// ----------------------------------------------------------------------------
module crt_bezout
    import crt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data,
    output crt_cfg_t             cfg
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOAD = 3'd1;
    localparam logic [2:0] S_RED  = 3'd2;
    localparam logic [2:0] S_SRCH = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    localparam logic [DIM_W:0] CNT_LAST = {1'b0, {DIM_W{1'b1}}};

    logic [2:0]       state_reg, state_next;
    logic [DIM_W-1:0] n_reg, n_next, m_reg, m_next, k_reg, k_next, l_reg, l_next;
    logic [DIM_W-1:0] mm_reg, mm_next, nn_reg, nn_next, ll_reg, ll_next;
    logic [DIM_W-1:0] acc_a_reg, acc_a_next, acc_b_reg, acc_b_next;
    logic [DIM_W-1:0] acc_c_reg, acc_c_next;
    logic [DIM_W-1:0] xa_reg, xa_next, yb_reg, yb_next;
    logic             fa_reg, fa_next, fb_reg, fb_next, fc_reg, fc_next;
    logic [DIM_W:0]   cnt_reg, cnt_next;
    logic [ST_W-1:0]  st_reg, st_next;
    logic [DIV_W-1:0] nm_reg, nm_next, kl_reg, kl_next;
    logic [DIV_W-1:0] ca_reg, ca_next, cb_reg, cb_next;
    logic [DIM_W-1:0] tgt_n, tgt_m, tgt_k;
    logic             size_bad;

    function automatic logic [DIM_W-1:0] add_mod(input logic [DIM_W-1:0] a,
                                                 input logic [DIM_W-1:0] b,
                                                 input logic [DIM_W-1:0] d);
        logic [DIM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, d})
        begin
            s = s - {1'b0, d};
        end
        return s[DIM_W-1:0];
    endfunction

    // The inverse we look for is one, except modulo one where it is zero.
    assign tgt_n = (n_reg == DIM_W'(1)) ? '0 : DIM_W'(1);
    assign tgt_m = (m_reg == DIM_W'(1)) ? '0 : DIM_W'(1);
    assign tgt_k = (k_reg == DIM_W'(1)) ? '0 : DIM_W'(1);

    assign size_bad = (n_reg == '0) || (m_reg == '0) || (k_reg == '0) || (l_reg == '0)
                   || (n_reg > DIM_W'(MAX_DIM)) || (m_reg > DIM_W'(MAX_DIM))
                   || (k_reg > DIM_W'(MAX_DIM)) || (l_reg > DIM_W'(MAX_DIM))
                   || (n_reg < k_reg) || (m_reg < l_reg);

    always_comb
    begin
        state_next = state_reg;
        n_next = n_reg;  m_next = m_reg;  k_next = k_reg;  l_next = l_reg;
        mm_next = mm_reg;  nn_next = nn_reg;  ll_next = ll_reg;
        acc_a_next = acc_a_reg;  acc_b_next = acc_b_reg;  acc_c_next = acc_c_reg;
        xa_next = xa_reg;  yb_next = yb_reg;
        fa_next = fa_reg;  fb_next = fb_reg;  fc_next = fc_reg;
        cnt_next = cnt_reg;
        st_next = st_reg;  nm_next = nm_reg;  kl_next = kl_reg;
        ca_next = ca_reg;  cb_next = cb_reg;

        unique case (state_reg)
            S_IDLE:
            begin
            end
            S_LOAD:
            begin
                mm_next = m_reg;
                nn_next = n_reg;
                ll_next = l_reg;
                acc_a_next = '0;
                acc_b_next = '0;
                acc_c_next = '0;
                fa_next = 1'b0;
                fb_next = 1'b0;
                fc_next = 1'b0;
                cnt_next = '0;
                state_next = S_RED;
            end
            S_RED:
            begin
                // Reduce each step size below its modulus, one subtraction a cycle.
                if (n_reg != '0 && mm_reg >= n_reg)
                begin
                    mm_next = mm_reg - n_reg;
                end
                if (m_reg != '0 && nn_reg >= m_reg)
                begin
                    nn_next = nn_reg - m_reg;
                end
                if (k_reg != '0 && ll_reg >= k_reg)
                begin
                    ll_next = ll_reg - k_reg;
                end
                if ((n_reg == '0 || mm_reg < n_reg) && (m_reg == '0 || nn_reg < m_reg)
                    && (k_reg == '0 || ll_reg < k_reg))
                begin
                    state_next = S_SRCH;
                end
            end
            S_SRCH:
            begin
                if (!fa_reg && cnt_reg < {1'b0, n_reg} && acc_a_reg == tgt_n)
                begin
                    fa_next = 1'b1;
                    xa_next = cnt_reg[DIM_W-1:0];
                end
                if (!fb_reg && cnt_reg < {1'b0, m_reg} && acc_b_reg == tgt_m)
                begin
                    fb_next = 1'b1;
                    yb_next = cnt_reg[DIM_W-1:0];
                end
                if (!fc_reg && cnt_reg < {1'b0, k_reg} && acc_c_reg == tgt_k)
                begin
                    fc_next = 1'b1;
                end
                acc_a_next = add_mod(acc_a_reg, mm_reg, n_reg);
                acc_b_next = add_mod(acc_b_reg, nn_reg, m_reg);
                acc_c_next = add_mod(acc_c_reg, ll_reg, k_reg);
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                nm_next = DIV_W'(n_reg) * DIV_W'(m_reg);
                kl_next = DIV_W'(k_reg) * DIV_W'(l_reg);
                ca_next = DIV_W'(m_reg) * DIV_W'(xa_reg);
                cb_next = DIV_W'(n_reg) * DIV_W'(yb_reg);
                if (size_bad)
                begin
                    st_next = ST_SIZE;
                end
                else if (!(fa_reg && fc_reg))
                begin
                    st_next = ST_COPRIME;
                end
                else
                begin
                    st_next = ST_OK;
                end
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_DIM_N: n_next = cfg_data;
                REG_DIM_M: m_next = cfg_data;
                REG_SUB_K: k_next = cfg_data;
                REG_SUB_L: l_next = cfg_data;
                default:
                begin
                end
            endcase
            state_next = S_LOAD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            n_reg <= DIM_W'(1);  m_reg <= DIM_W'(1);
            k_reg <= DIM_W'(1);  l_reg <= DIM_W'(1);
            mm_reg <= '0;  nn_reg <= '0;  ll_reg <= '0;
            acc_a_reg <= '0;  acc_b_reg <= '0;  acc_c_reg <= '0;
            xa_reg <= '0;  yb_reg <= '0;
            fa_reg <= 1'b0;  fb_reg <= 1'b0;  fc_reg <= 1'b0;
            cnt_reg <= '0;
            st_reg <= ST_OK;
            nm_reg <= DIV_W'(1);  kl_reg <= DIV_W'(1);
            ca_reg <= '0;  cb_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            n_reg <= n_next;  m_reg <= m_next;  k_reg <= k_next;  l_reg <= l_next;
            mm_reg <= mm_next;  nn_reg <= nn_next;  ll_reg <= ll_next;
            acc_a_reg <= acc_a_next;  acc_b_reg <= acc_b_next;  acc_c_reg <= acc_c_next;
            xa_reg <= xa_next;  yb_reg <= yb_next;
            fa_reg <= fa_next;  fb_reg <= fb_next;  fc_reg <= fc_next;
            cnt_reg <= cnt_next;
            st_reg <= st_next;
            nm_reg <= nm_next;  kl_reg <= kl_next;
            ca_reg <= ca_next;  cb_reg <= cb_next;
        end
    end

    assign cfg_ready   = 1'b1;
    assign cfg.busy    = (state_reg != S_IDLE);
    assign cfg.status  = st_reg;
    assign cfg.sub_k   = k_reg;
    assign cfg.sub_l   = l_reg;
    assign cfg.nm      = nm_reg;
    assign cfg.kl      = kl_reg;
    assign cfg.coef_a  = ca_reg;
    assign cfg.coef_b  = cb_reg;

endmodule

[design/crt_mod_stage.sv]
// ----------------------------------------------------------------------------
// crt_mod_stage
// One pipeline stage of a restoring remainder unit: four bits per stage.
// ----------------------------------------------------------------------------
module crt_mod_stage
    import crt_pkg::*;
(
    input  logic             clk,
    input  logic             en,
    input  crt_mod_t         d_in,
    input  logic [DIV_W-1:0] divisor,
    output crt_mod_t         q
);

    crt_mod_t q_reg, q_next;

    always_comb
    begin
        logic [DIV_W:0]   t;
        logic [DIV_W-1:0] rem;
        logic [X_W-1:0]   x;
        rem = d_in.rem;
        x   = d_in.x;
        for (int i = 0; i < STEPS; i++)
        begin
            t = {rem, x[X_W-1]};
            x = {x[X_W-2:0], 1'b0};
            if (t >= {1'b0, divisor})
            begin
                t = t - {1'b0, divisor};
            end
            rem = t[DIV_W-1:0];
        end
        q_next.rem = rem;
        q_next.x   = x;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

[design/crt_submatrix_index_map.sv]
// ----------------------------------------------------------------------------
// crt_submatrix_index_map
// Maps a row index to the column of the one in a CRT selection matrix.
// ----------------------------------------------------------------------------
// Usage: write dim_n, dim_m, sub_k and sub_l through the cfg channel (index
// 0 to 3, cfg_ready is always high). Each write restarts a sequencer that
// reduces the step sizes and searches the modular inverses, one candidate
// a cycle; while it runs, row_stall is held high. Requests then enter on
// row_valid/row_index and results leave on col_valid with row_echo,
// column_index and status.
// Throughput is one request per cycle while row_stall is low. Requests
// pass three stages of r mod k and r mod l, one multiply stage, five
// stages of the final reduction mod n*m, and the output register before
// col_valid, each remainder stage resolving four quotient bits.
// When col_stall is high with a result waiting, the whole pipeline holds
// and row_stall goes high in the same cycle; nothing is dropped.
// After reset all four registers are 1 and requests are taken at once.
// ----------------------------------------------------------------------------
module crt_submatrix_index_map
    import crt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data,
    input  logic                 row_valid,
    output logic                 row_stall,
    input  logic [ROW_W-1:0]     row_index,
    output logic                 col_valid,
    input  logic                 col_stall,
    output logic [ROW_W-1:0]     row_echo,
    output logic [COL_W-1:0]     column_index,
    output logic [ST_W-1:0]      status
);

    crt_cfg_t cfg;
    logic     en, accept;
    logic [ST_W-1:0] st_in;

    logic [PIPE_DEPTH-1:0] vld_reg;
    logic [ROW_W-1:0]      r_reg  [PIPE_DEPTH];
    logic [ST_W-1:0]       st_reg [PIPE_DEPTH];
    logic [COL_W-1:0]      col_reg;

    crt_mod_t kd [K_STAGES+1];
    crt_mod_t ld [K_STAGES+1];
    crt_mod_t fd [F_STAGES+1];

    logic [X_W-1:0]         pa_reg, pb_reg;
    logic [DIV_W+DIM_W-1:0] pa_full, pb_full;
    logic [X_W-1:0]         sum;

    crt_bezout u_bezout (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign en        = !(vld_reg[PIPE_DEPTH-1] && col_stall);
    assign row_stall = !en || cfg.busy;
    assign accept    = row_valid && !row_stall;

    always_comb
    begin
        if (cfg.status != ST_OK)
        begin
            st_in = cfg.status;
        end
        else if ({{(DIV_W-ROW_W){1'b0}}, row_index} >= cfg.kl)
        begin
            st_in = ST_RANGE;
        end
        else
        begin
            st_in = ST_OK;
        end
    end

    assign kd[0].rem = '0;
    assign kd[0].x   = {row_index, {(X_W-ROW_W){1'b0}}};
    assign ld[0]     = kd[0];

    for (genvar i = 0; i < K_STAGES; i++)
    begin : g_rk
        crt_mod_stage u_mk (
            .clk     (clk),
            .en      (en),
            .d_in    (kd[i]),
            .divisor ({{(DIV_W-DIM_W){1'b0}}, cfg.sub_k}),
            .q       (kd[i+1])
        );
        crt_mod_stage u_ml (
            .clk     (clk),
            .en      (en),
            .d_in    (ld[i]),
            .divisor ({{(DIV_W-DIM_W){1'b0}}, cfg.sub_l}),
            .q       (ld[i+1])
        );
    end

    assign pa_full = kd[K_STAGES].rem[DIM_W-1:0] * cfg.coef_a;
    assign pb_full = ld[K_STAGES].rem[DIM_W-1:0] * cfg.coef_b;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pa_reg <= pa_full[X_W-1:0];
            pb_reg <= pb_full[X_W-1:0];
        end
    end

    // With valid dimensions both products stay below 2^18, so the sum cannot overflow.
    assign sum      = pa_reg + pb_reg;
    assign fd[0].rem = '0;
    assign fd[0].x   = sum;

    for (genvar j = 0; j < F_STAGES; j++)
    begin : g_fm
        crt_mod_stage u_mf (
            .clk     (clk),
            .en      (en),
            .d_in    (fd[j]),
            .divisor (cfg.nm),
            .q       (fd[j+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[PIPE_DEPTH-2:0], accept};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg[0]  <= row_index;
            st_reg[0] <= st_in;
            for (int p = 1; p < PIPE_DEPTH; p++)
            begin
                r_reg[p]  <= r_reg[p-1];
                st_reg[p] <= st_reg[p-1];
            end
            col_reg <= (st_reg[PIPE_DEPTH-2] == ST_OK) ? fd[F_STAGES].rem[COL_W-1:0] : '0;
        end
    end

    assign col_valid    = vld_reg[PIPE_DEPTH-1];
    assign row_echo     = r_reg[PIPE_DEPTH-1];
    assign status       = st_reg[PIPE_DEPTH-1];
    assign column_index = col_reg;

    a_err_col_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (col_valid && status != ST_OK) |-> (column_index == '0))
        else $error("column not zero on an error result");

    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (col_valid && status == ST_OK) |-> ({{(DIV_W-COL_W){1'b0}}, column_index} < cfg.nm))
        else $error("column beyond n*m");

    a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (col_valid && status == ST_OK) |-> ({{(DIV_W-ROW_W){1'b0}}, row_echo} < cfg.kl))
        else $error("ok status on a row beyond k*l");

    a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
        cfg.busy |-> row_stall)
        else $error("request taken while weights are being derived");

endmodule

[dv/crt_index_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// crt_index_checker
// Watches the register, request and result channels of the CRT index map,
// predicts each result from its own copy of the dimensions and compares.
// ----------------------------------------------------------------------------
module crt_index_checker
    import crt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data,
    input  logic                 row_valid,
    input  logic                 row_stall,
    input  logic [ROW_W-1:0]     row_index,
    input  logic                 col_valid,
    input  logic                 col_stall,
    input  logic [ROW_W-1:0]     row_echo,
    input  logic [COL_W-1:0]     column_index,
    input  logic [ST_W-1:0]      status,
    output int                   mismatches,
    output int                   pending,
    output int                   mapped_ok,
    output int                   flagged
);

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [ST_W-1:0]  st;
    } crt_col_result_t;

    logic [DIM_W-1:0] cur_n, cur_m, cur_k, cur_l;
    crt_col_result_t  expected_cols[$];

    function automatic longint euclid_gcd(longint a, longint b);
        longint rem;
        while (b != 0)
        begin
            rem = a % b;
            a   = b;
            b   = rem;
        end
        return a;
    endfunction

    // Builds the column for row r under the current dimensions.
    function automatic crt_col_result_t map_row(logic [ROW_W-1:0] r);
        crt_col_result_t res;
        longint n, m, k, l, a, b, q, tmp, px, cx, py, cy, v, nm;
        n = cur_n;
        m = cur_m;
        k = cur_k;
        l = cur_l;
        res.row = r;
        res.col = '0;
        res.st  = ST_OK;
        if (n == 0 || m == 0 || k == 0 || l == 0 || n > MAX_DIM || m > MAX_DIM ||
            k > MAX_DIM || l > MAX_DIM || n < k || m < l)
        begin
            res.st = ST_SIZE;
            return res;
        end
        a  = n;
        b  = m;
        px = 1;
        cx = 0;
        py = 0;
        cy = 1;
        while (b != 0)
        begin
            q   = a / b;
            tmp = a % b;
            a   = b;
            b   = tmp;
            tmp = cx; cx = px - q * cx; px = tmp;
            tmp = cy; cy = py - q * cy; py = tmp;
        end
        if (a != 1 || euclid_gcd(k, l) != 1)
            res.st = ST_COPRIME;
        else if (longint'(r) >= k * l)
            res.st = ST_RANGE;
        else
        begin
            nm = n * m;
            v  = (longint'(r) % k) * py * m + (longint'(r) % l) * px * n;
            v  = v % nm;
            if (v < 0)
                v += nm;
            res.col = v[COL_W-1:0];
        end
        return res;
    endfunction

    assign pending = expected_cols.size();

    always @(posedge clk or negedge rst_n)
    begin
        crt_col_result_t want;
        if (!rst_n)
        begin
            cur_n <= 1;
            cur_m <= 1;
            cur_k <= 1;
            cur_l <= 1;
            expected_cols.delete();
            mismatches <= 0;
            mapped_ok  <= 0;
            flagged    <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_DIM_N: cur_n <= cfg_data;
                    REG_DIM_M: cur_m <= cfg_data;
                    REG_SUB_K: cur_k <= cfg_data;
                    REG_SUB_L: cur_l <= cfg_data;
                    default: ;
                endcase
            end
            if (row_valid && !row_stall)
                expected_cols = {expected_cols, map_row(row_index)};
            if (col_valid && !col_stall)
            begin
                if (expected_cols.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("%0t: unexpected result row %0d col %0d status %0d",
                                 $realtime, row_echo, column_index, status);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    want = expected_cols.pop_front();
                    if (want.row !== row_echo || want.col !== column_index ||
                        want.st !== status)
                    begin
                        if (mismatches < 10)
                            $display("%0t: row %0d/%0d col %0d/%0d status %0d/%0d (exp/act)",
                                     $realtime, want.row, row_echo, want.col,
                                     column_index, want.st, status);
                        mismatches <= mismatches + 1;
                    end
                    if (want.st == ST_OK)
                        mapped_ok <= mapped_ok + 1;
                    else
                        flagged <= flagged + 1;
                end
            end
        end
    end

endmodule

[dv/crt_submatrix_index_map_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// crt_submatrix_index_map_tb
// Drives dimension settings and row requests with random gaps and stalls,
// including one long output hold-off; a checker compares every result.
// ----------------------------------------------------------------------------
module crt_submatrix_index_map_tb;
    import crt_pkg::*;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DIM_W-1:0]     cfg_data;
    logic                 row_valid;
    logic                 row_stall;
    logic [ROW_W-1:0]     row_index;
    logic                 col_valid;
    logic                 col_stall;
    logic [ROW_W-1:0]     row_echo;
    logic [COL_W-1:0]     column_index;
    logic [ST_W-1:0]      status;

    int mismatches, pending, mapped_ok, flagged;
    int n_sel, m_sel, k_sel, l_sel;
    int settings_used;
    logic hold_request;
    logic hold_done;
    logic burst_mode;

    crt_submatrix_index_map u_dut (.*);

    crt_index_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = 1'b1;
            #5 clk = 1'b0;
        end
    end

    initial
    begin
        #5ms;
        $display("timeout with %0d results outstanding", pending);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Result side: random stall runs, plus one long hold when requested.
    initial
    begin
        int run_len;
        int hold_cnt;
        col_stall = 1'b0;
        hold_done = 1'b0;
        run_len   = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request && !hold_done)
            begin
                for (hold_cnt = 0; hold_cnt < 400; hold_cnt++)
                begin
                    col_stall <= 1'b1;
                    @(negedge clk);
                end
                hold_done <= 1'b1;
                col_stall <= 1'b0;
                run_len   = 0;
            end
            else if (run_len > 0)
                run_len--;
            else if (burst_mode || $urandom_range(1, 2) == 1)
            begin
                col_stall <= 1'b0;
                run_len = burst_mode ? 0 : $urandom_range(0, 20);
            end
            else
            begin
                col_stall <= 1'b1;
                run_len = ($urandom_range(1, 10) == 1) ? $urandom_range(20, 60)
                                                       : $urandom_range(0, 2);
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[DIM_W-1:0];
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Drops the request line and waits until every result has come back.
    task automatic drain();
        @(negedge clk);
        row_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
    endtask

    // Waits until every result has come back, then loads a new setting.
    task automatic load_dims(int n, int m, int k, int l);
        drain();
        write_reg(REG_DIM_N, n);
        write_reg(REG_DIM_M, m);
        write_reg(REG_SUB_K, k);
        write_reg(REG_SUB_L, l);
        settings_used++;
    endtask

    task automatic send_row(int unsigned r);
        int gap;
        @(negedge clk);
        row_valid <= 1'b1;
        row_index <= r[ROW_W-1:0];
        do @(posedge clk); while (row_stall);
        if (burst_mode)
            gap = 0;
        else if ($urandom_range(1, 10) <= 6)
            gap = 0;
        else if ($urandom_range(1, 4) != 1)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(10, 40);
        if (gap > 0)
        begin
            @(negedge clk);
            row_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    function automatic int small_gcd(int a, int b);
        int rem;
        while (b != 0)
        begin
            rem = a % b;
            a   = b;
            b   = rem;
        end
        return a;
    endfunction

    // Mostly valid coprime dimensions; now and then arbitrary 7-bit values.
    task automatic pick_dims();
        if ($urandom_range(1, 6) == 1)
        begin
            n_sel = $urandom_range(0, 127);
            m_sel = $urandom_range(0, 127);
            k_sel = $urandom_range(0, 127);
            l_sel = $urandom_range(0, 127);
            return;
        end
        do
        begin
            n_sel = $urandom_range(1, MAX_DIM);
            m_sel = $urandom_range(1, MAX_DIM);
        end while (small_gcd(n_sel, m_sel) != 1);
        do
        begin
            k_sel = $urandom_range(1, n_sel);
            l_sel = $urandom_range(1, m_sel);
        end while (small_gcd(k_sel, l_sel) != 1 && $urandom_range(1, 8) != 1);
    endtask

    initial
    begin
        int phase;
        int kl;
        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        row_valid    = 1'b0;
        row_index    = '0;
        hold_request = 1'b0;
        burst_mode   = 1'b0;
        settings_used = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset dimensions: only row 0 is in range.
        send_row(0);
        send_row(1);
        send_row(4095);

        load_dims(64, 63, 64, 63);
        send_row(0);
        send_row(4031);
        send_row(4032);
        send_row(2730);
        send_row(1365);
        // An unknown register index must leave the setting alone.
        drain();
        write_reg(8'd200, 5);
        write_reg(8'hFF, 127);
        send_row(100);

        load_dims(63, 64, 63, 64);
        send_row(4031);
        load_dims(6, 4, 3, 2);      // n and m share a factor
        send_row(5);
        load_dims(64, 63, 8, 6);    // k and l share a factor
        send_row(7);
        load_dims(5, 7, 6, 3);      // k above n
        send_row(2);
        load_dims(5, 7, 5, 8);      // l above m
        send_row(2);
        load_dims(0, 7, 1, 1);
        send_row(0);
        load_dims(127, 127, 127, 127);
        send_row(4095);
        load_dims(65, 64, 1, 1);
        send_row(0);
        load_dims(2, 3, 2, 3);
        send_row(5);
        send_row(6);

        for (phase = 0; phase < 19; phase++)
        begin
            pick_dims();
            load_dims(n_sel, m_sel, k_sel, l_sel);
            burst_mode = (phase % 4 == 1);
            if (phase == 6)
                hold_request = 1'b1;
            kl = k_sel * l_sel;
            repeat (40)
            begin
                if ($urandom_range(1, 100) <= 85 && kl > 0 && kl <= 4096)
                    send_row($urandom_range(0, kl - 1));
                else
                    send_row($urandom_range(0, 4095));
            end
            burst_mode = 1'b0;
        end

        drain();
        repeat (30) @(posedge clk);
        $display("%0d dimension settings, %0d rows mapped and %0d rows flagged",
                 settings_used, mapped_ok, flagged);
        if (mismatches == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[sim.f]
design/crt_pkg.sv
design/crt_bezout.sv
design/crt_mod_stage.sv
design/crt_submatrix_index_map.sv
dv/crt_index_checker.sv
dv/crt_submatrix_index_map_tb.sv
